/* hdl/cppt_pkg.sv */
// ----------------------------------------------------------------------------
// cppt_pkg: shared types for the convex polygon point test
// Input and result words, request codes, register addresses and state codes.
// ----------------------------------------------------------------------------
package cppt_pkg;

  localparam int COORD_W  = 24;
  localparam int NORMAL_W = 16;

  typedef struct packed {
    logic                      req_type;
    logic                      first_vertex;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic is_inside;
    logic polygon_empty;
    logic vertex_overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  localparam logic [1:0] REG_NORMAL_X = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [1:0] REG_NORMAL_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

/* hdl/cppt_cell.sv */
// ----------------------------------------------------------------------------
// cppt_cell: one vertex slot of the vertex ring
// Holds a vertex; on shift it loads prev_vertex (new data on load, the neighbor on walk).
// ----------------------------------------------------------------------------
module cppt_cell (
  input  logic             clk,
  input  logic             shift,
  input  cppt_pkg::vertex_t prev_vertex,
  output cppt_pkg::vertex_t vertex
);
  import cppt_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      vertex <= prev_vertex;
    end
  end
endmodule

/* hdl/cppt_edge.sv */
// ----------------------------------------------------------------------------
// cppt_edge: edge sign evaluator
// Four stage pipeline of the triple product d1 . (n x d0), exact width.
// ----------------------------------------------------------------------------
module cppt_edge (
  input  logic                       clk,
  input  logic signed [15:0]         nx,
  input  logic signed [15:0]         ny,
  input  logic signed [15:0]         nz,
  input  cppt_pkg::vertex_t          v0,
  input  cppt_pkg::vertex_t          v1,
  input  cppt_pkg::vertex_t          q,
  output logic signed [1:0]          sgn
);
  import cppt_pkg::*;

  logic signed [24:0] d0x, d0y, d0z, d1x, d1y, d1z;
  logic signed [24:0] r0x, r0y, r0z, r1x, r1y, r1z;
  logic signed [41:0] p1, p2, p3, p4, p5, p6;
  logic signed [42:0] cx, cy, cz;
  logic signed [24:0] e1x, e1y, e1z;
  logic signed [46:0] h1, h2, h3, l1, l2, l3;
  logic signed [67:0] m1, m2, m3;
  logic signed [69:0] s;

  assign d0x = 25'(v0.x) - 25'(q.x);
  assign d0y = 25'(v0.y) - 25'(q.y);
  assign d0z = 25'(v0.z) - 25'(q.z);
  assign d1x = 25'(v1.x) - 25'(q.x);
  assign d1y = 25'(v1.y) - 25'(q.y);
  assign d1z = 25'(v1.z) - 25'(q.z);

  // split each cross term into a signed upper half and an unsigned lower half
  always_ff @(posedge clk) begin
    r0x <= d0x; r0y <= d0y; r0z <= d0z;
    r1x <= d1x; r1y <= d1y; r1z <= d1z;
    p1 <= 42'(ny * r0z); p2 <= 42'(nz * r0y);
    p3 <= 42'(nz * r0x); p4 <= 42'(nx * r0z);
    p5 <= 42'(nx * r0y); p6 <= 42'(ny * r0x);
    e1x <= r1x; e1y <= r1y; e1z <= r1z;
    h1 <= 47'(e1x * $signed(cx[42:21]));
    h2 <= 47'(e1y * $signed(cy[42:21]));
    h3 <= 47'(e1z * $signed(cz[42:21]));
    l1 <= 47'(e1x * $signed({1'b0, cx[20:0]}));
    l2 <= 47'(e1y * $signed({1'b0, cy[20:0]}));
    l3 <= 47'(e1z * $signed({1'b0, cz[20:0]}));
    m1 <= (68'(h1) <<< 21) + 68'(l1);
    m2 <= (68'(h2) <<< 21) + 68'(l2);
    m3 <= (68'(h3) <<< 21) + 68'(l3);
  end

  assign cx = 43'(p1) - 43'(p2);
  assign cy = 43'(p3) - 43'(p4);
  assign cz = 43'(p5) - 43'(p6);
  assign s  = 70'(m1) + 70'(m2) + 70'(m3);

  always_comb begin
    if (s[69])        sgn = -2'sd1;
    else if (s == '0) sgn = 2'sd0;
    else              sgn = 2'sd1;
  end
endmodule

/* hdl/convex_polygon_point_test.sv */
// Input: a word is taken only while idle; a query walks the ring, and out_valid is
// registered from ST_DONE; an empty list goes straight from ST_IDLE to ST_DONE.
// Throughput: one word at a time; a query holds the input while the ring turns full
// circles through the four stage edge pipeline; a waiting result also stalls the
// input.
// Reset (rst, synchronous): vertex count, overflow mark and control clear;
// normal resets to (0, 0, 1.0). Vertex cells hold undefined data until loaded.
// ----------------------------------------------------------------------------
// convex_polygon_point_test: point in convex polygon test
// Ring of vertex cells feeding a pipelined edge sign unit.
// ----------------------------------------------------------------------------
module convex_polygon_point_test #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cppt_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cppt_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cppt_pkg::*;

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int LAT = 4;

  logic signed [15:0] nx, ny, nz;
  vertex_t cells [MAX_VERTICES];
  logic [CW-1:0] count, cnt_next;
  logic overflow, ovf_next;
  state_t state, state_next;
  vertex_t q;
  logic [CW-1:0] issued, issued_next;
  logic [CW+2:0] retired, retired_next;
  logic signed [1:0] refs, refs_next, sgn;
  logic in_poly, in_poly_next;
  logic [LAT-1:0] vpipe;
  logic load, shift, take, res_wr;
  vertex_t prev_v;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= '0; ny <= '0; nz <= 16'sd16384;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NORMAL_X: nx <= pwdata[15:0];
        REG_NORMAL_Y: ny <= pwdata[15:0];
        REG_NORMAL_Z: nz <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_NORMAL_X: prdata = 32'(nx);
      REG_NORMAL_Y: prdata = 32'(ny);
      REG_NORMAL_Z: prdata = 32'(nz);
      default:      prdata = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign take = in_valid && !in_stall;
  assign cnt_next = (in_data.first_vertex) ? '0 : count;
  assign load = take && in_data.req_type == REQ_LOAD && cnt_next < CW'(MAX_VERTICES);
  assign shift = load || (state == ST_WALK);

  // cell 0 is the oldest (first) vertex; a load writes at the tail
  genvar g;
  generate
    for (g = 0; g < MAX_VERTICES; g++) begin : g_ring
      vertex_t src;
      always_comb begin
        if (state == ST_WALK)
          src = cells[(g + 1) % MAX_VERTICES];
        else if (CW'(g) == cnt_next)
          src = vertex_t'{in_data.coord_x, in_data.coord_y, in_data.coord_z};
        else
          src = cells[g];
      end
      cppt_cell u_cell (.clk(clk), .shift(shift), .prev_vertex(src),
                        .vertex(cells[g]));
    end
  endgenerate

  // walk rotates full ring: each cell takes its upper neighbor, so vertices pass cell 0
  logic [CW-1:0] rot;
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) prev_v <= cells[IW'(count - CW'(1))];
    else if (state == ST_WALK) prev_v <= cells[0];
  end

  cppt_edge u_edge (
    .clk(clk), .nx(nx), .ny(ny), .nz(nz),
    .v0(prev_v), .v1(cells[0]), .q(q), .sgn(sgn)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; overflow <= 1'b0;
    end else if (take && in_data.req_type == REQ_LOAD) begin
      count <= load ? cnt_next + CW'(1) : cnt_next;
      overflow <= load ? (in_data.first_vertex ? 1'b0 : overflow) : 1'b1;
    end
  end
  assign ovf_next = overflow;

  always_ff @(posedge clk) begin
    if (take) q <= vertex_t'{in_data.coord_x, in_data.coord_y, in_data.coord_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; issued <= '0; retired <= '0; rot <= '0;
      refs <= '0; in_poly <= 1'b1; vpipe <= '0;
    end else begin
      state <= state_next; issued <= issued_next; retired <= retired_next;
      refs <= refs_next; in_poly <= in_poly_next;
      vpipe <= {vpipe[LAT-2:0], state == ST_WALK && issued < count};
      rot <= (state == ST_WALK) ? ((rot == CW'(MAX_VERTICES - 1)) ? '0 : rot + CW'(1))
                                : '0;
    end
  end

  // walk ends on a rotation boundary (rot at MAX_VERTICES - 1) so the ring returns to its order
  always_comb begin
    state_next = state; issued_next = issued; retired_next = retired;
    refs_next = refs; in_poly_next = in_poly; res_wr = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take && in_data.req_type == REQ_TEST) begin
          refs_next = '0; in_poly_next = 1'b1; issued_next = '0; retired_next = '0;
          state_next = (count == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (issued < count) issued_next = issued + CW'(1);
        if (vpipe[LAT-1]) begin
          retired_next = retired + (CW+3)'(1);
          if (refs == 2'sd0) refs_next = sgn;
          if ((refs == 2'sd1 && sgn == -2'sd1) || (refs == -2'sd1 && sgn == 2'sd1))
            in_poly_next = 1'b0;
        end
        if (rot == CW'(MAX_VERTICES - 1) && retired_next == (CW+3)'(count))
          state_next = ST_DONE;
      end
      ST_DONE: begin
        res_wr = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_wr) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_wr) begin
      out_data.is_inside       <= (count != '0) && in_poly;
      out_data.polygon_empty   <= (count == '0);
      out_data.vertex_overflow <= ovf_next;
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_VERTICES)) else $error("vertex count beyond capacity");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("input taken while busy");
  a_ret: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> retired <= (CW+3)'(count))
    else $error("more edges retired than loaded");
endmodule
